FILE: rtl/sffe_pkg.sv
// ----------------------------------------------------------------------------
// sffe_pkg
// Shared types, codes and defaults for the stack flood fill engine.
// ----------------------------------------------------------------------------
package sffe_pkg;

	// Default geometry
	localparam int unsigned DEF_MAX_WIDTH   = 256;
	localparam int unsigned DEF_MAX_HEIGHT  = 256;
	localparam int unsigned DEF_STACK_DEPTH = 65536;

	// Width of window limits (holds up to 8191)
	localparam int unsigned DIM_W = 13;
	localparam int unsigned REG_W = 9;

	localparam logic [7:0] ALPHA_BYTE = 8'hFF;

	// Command codes
	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_FILL  = 2'd2;

	// Status codes
	localparam logic [1:0] ST_READ_OK   = 2'd0;
	localparam logic [1:0] ST_FILL_DONE = 2'd1;
	localparam logic [1:0] ST_OVERFLOW  = 2'd2;
	localparam logic [1:0] ST_BAD_COORD = 2'd3;

	// Register indexes
	localparam logic REG_FRAME_WIDTH  = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [7:0]  pos_x;
		logic [7:0]  pos_y;
		logic [31:0] pixel_value;
		logic [7:0]  fill_red;
		logic [7:0]  fill_green;
		logic [7:0]  fill_blue;
	} in_word_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic [1:0]  status;
	} out_word_t;

	// Active window, already clamped to the maximum frame geometry
	typedef struct packed {
		logic [DIM_W-1:0] w;
		logic [DIM_W-1:0] h;
	} win_t;

endpackage

FILE: rtl/sffe_core.sv
// ----------------------------------------------------------------------------
// sffe_core
// Frame store, coordinate stack and the sequencer for pixel access and fill.
// ----------------------------------------------------------------------------
module sffe_core #(
	parameter int unsigned MAX_WIDTH   = sffe_pkg::DEF_MAX_WIDTH,
	parameter int unsigned MAX_HEIGHT  = sffe_pkg::DEF_MAX_HEIGHT,
	parameter int unsigned STACK_DEPTH = sffe_pkg::DEF_STACK_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  sffe_pkg::in_word_t  req,
	input  sffe_pkg::win_t      win,
	output logic                busy,
	output logic                result_valid,
	output sffe_pkg::out_word_t result
);

	localparam int unsigned XW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int unsigned YW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int unsigned AW  = $clog2(MAX_WIDTH * MAX_HEIGHT);
	localparam int unsigned SIW = $clog2(STACK_DEPTH);
	localparam int unsigned SPW = SIW + 1;
	localparam int unsigned EW  = XW + YW;
	localparam int unsigned FRAME_WORDS = MAX_WIDTH * MAX_HEIGHT;
	localparam int unsigned DW  = sffe_pkg::DIM_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD_WAIT,
		S_POP,
		S_PAINT,
		S_NB_ISSUE,
		S_NB_CMP
	} state_t;

	function automatic logic [AW-1:0] addr_of(input logic [XW-1:0] x, input logic [YW-1:0] y);
		addr_of = AW'(y) * AW'(MAX_WIDTH) + AW'(x);
	endfunction

	state_t           state_q;
	logic [SPW-1:0]   sp_q;
	logic [XW-1:0]    cur_x_q, nb_x_q;
	logic [YW-1:0]    cur_y_q, nb_y_q;
	logic [31:0]      colour_q, ref_q;
	logic [1:0]       k_q;
	logic             is_fill_q;
	logic             res_valid_q;
	sffe_pkg::out_word_t res_q;

	// memories
	logic [31:0] frame_mem [FRAME_WORDS];
	logic [EW-1:0] stack_mem [STACK_DEPTH];
	logic [31:0] fb_rdata_q;
	logic [EW-1:0] st_rdata_q;

	logic          fb_we, fb_re;
	logic [AW-1:0] fb_waddr, fb_raddr;
	logic [31:0]   fb_wdata;
	logic          st_we;
	logic [SIW-1:0] st_waddr, st_raddr;
	logic [EW-1:0] st_wdata;

	// request decode
	logic           in_win;
	logic [XW-1:0]  req_x;
	logic [YW-1:0]  req_y;
	logic [31:0]    req_colour;
	logic           accept;

	assign accept = start && (state_q == S_IDLE);
	assign in_win = (DW'(req.pos_x) < win.w) && (DW'(req.pos_y) < win.h);
	assign req_x  = XW'(req.pos_x);
	assign req_y  = YW'(req.pos_y);
	assign req_colour = {sffe_pkg::ALPHA_BYTE, req.fill_red, req.fill_green, req.fill_blue};

	// neighbor candidate: left, up, right, down
	logic [XW-1:0] cand_x;
	logic [YW-1:0] cand_y;
	logic          cand_ok;
	logic          stack_full;
	logic [XW-1:0] pop_x;
	logic [YW-1:0] pop_y;

	assign stack_full = (sp_q == SPW'(STACK_DEPTH));
	assign pop_x = st_rdata_q[XW-1:0];
	assign pop_y = st_rdata_q[EW-1:XW];

	always_comb begin
		cand_x  = cur_x_q;
		cand_y  = cur_y_q;
		cand_ok = 1'b0;
		unique case (k_q)
			2'd0: begin
				cand_x  = cur_x_q - XW'(1);
				cand_ok = (cur_x_q != '0);
			end
			2'd1: begin
				cand_y  = cur_y_q - YW'(1);
				cand_ok = (cur_y_q != '0);
			end
			2'd2: begin
				cand_x  = cur_x_q + XW'(1);
				cand_ok = (DW'(cur_x_q) + DW'(1)) < win.w;
			end
			default: begin
				cand_y  = cur_y_q + YW'(1);
				cand_ok = (DW'(cur_y_q) + DW'(1)) < win.h;
			end
		endcase
	end

	// memory controls
	always_comb begin
		fb_we    = 1'b0;
		fb_re    = 1'b0;
		fb_waddr = addr_of(req_x, req_y);
		fb_raddr = addr_of(req_x, req_y);
		fb_wdata = req.pixel_value;
		st_we    = 1'b0;
		st_waddr = sp_q[SIW-1:0];
		st_wdata = {nb_y_q, nb_x_q};
		st_raddr = SIW'(sp_q - SPW'(1));
		unique case (state_q)
			S_IDLE: begin
				if (start && in_win) begin
					fb_we = (req.cmd == sffe_pkg::CMD_WRITE);
					fb_re = (req.cmd == sffe_pkg::CMD_READ) || (req.cmd == sffe_pkg::CMD_FILL);
				end
			end
			S_RD_WAIT: begin
				if (is_fill_q && fb_rdata_q != colour_q) begin
					st_we    = 1'b1;
					st_waddr = '0;
					st_wdata = {cur_y_q, cur_x_q};
				end
			end
			S_PAINT: begin
				fb_we    = 1'b1;
				fb_waddr = addr_of(pop_x, pop_y);
				fb_wdata = colour_q;
			end
			S_NB_ISSUE: begin
				fb_re    = cand_ok;
				fb_raddr = addr_of(cand_x, cand_y);
			end
			S_NB_CMP: begin
				st_we = (fb_rdata_q == ref_q) && !stack_full;
			end
			default: ;
		endcase
	end

	// frame store, one write and one registered read
	always_ff @(posedge clk) begin
		if (fb_we) begin
			frame_mem[fb_waddr] <= fb_wdata;
		end
		if (fb_re) begin
			fb_rdata_q <= frame_mem[fb_raddr];
		end
	end

	// coordinate stack
	always_ff @(posedge clk) begin
		if (st_we) begin
			stack_mem[st_waddr] <= st_wdata;
		end
		st_rdata_q <= stack_mem[st_raddr];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			sp_q        <= '0;
			k_q         <= '0;
			is_fill_q   <= 1'b0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
			cur_x_q     <= '0;
			cur_y_q     <= '0;
			nb_x_q      <= '0;
			nb_y_q      <= '0;
			colour_q    <= '0;
			ref_q       <= '0;
		end else begin
			res_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						cur_x_q   <= req_x;
						cur_y_q   <= req_y;
						colour_q  <= req_colour;
						is_fill_q <= (req.cmd == sffe_pkg::CMD_FILL);
						if (req.cmd == sffe_pkg::CMD_READ || req.cmd == sffe_pkg::CMD_FILL) begin
							if (in_win) begin
								state_q <= S_RD_WAIT;
							end else begin
								res_valid_q     <= 1'b1;
								res_q.read_data <= '0;
								res_q.status    <= sffe_pkg::ST_BAD_COORD;
							end
						end
					end
				end
				S_RD_WAIT: begin
					if (!is_fill_q) begin
						res_valid_q     <= 1'b1;
						res_q.read_data <= fb_rdata_q;
						res_q.status    <= sffe_pkg::ST_READ_OK;
						state_q         <= S_IDLE;
					end else if (fb_rdata_q == colour_q) begin
						res_valid_q     <= 1'b1;
						res_q.read_data <= '0;
						res_q.status    <= sffe_pkg::ST_FILL_DONE;
						state_q         <= S_IDLE;
					end else begin
						ref_q   <= fb_rdata_q;
						sp_q    <= SPW'(1);
						state_q <= S_POP;
					end
				end
				S_POP: begin
					sp_q    <= sp_q - SPW'(1);
					state_q <= S_PAINT;
				end
				S_PAINT: begin
					cur_x_q <= pop_x;
					cur_y_q <= pop_y;
					k_q     <= '0;
					state_q <= S_NB_ISSUE;
				end
				S_NB_ISSUE: begin
					nb_x_q <= cand_x;
					nb_y_q <= cand_y;
					if (cand_ok) begin
						state_q <= S_NB_CMP;
					end else if (k_q != 2'd3) begin
						k_q <= k_q + 2'd1;
					end else if (sp_q == '0) begin
						res_valid_q     <= 1'b1;
						res_q.read_data <= '0;
						res_q.status    <= sffe_pkg::ST_FILL_DONE;
						state_q         <= S_IDLE;
					end else begin
						state_q <= S_POP;
					end
				end
				S_NB_CMP: begin
					if (fb_rdata_q == ref_q && stack_full) begin
						// overflow: abort and empty the stack
						sp_q            <= '0;
						res_valid_q     <= 1'b1;
						res_q.read_data <= '0;
						res_q.status    <= sffe_pkg::ST_OVERFLOW;
						state_q         <= S_IDLE;
					end else begin
						if (fb_rdata_q == ref_q) begin
							sp_q <= sp_q + SPW'(1);
						end
						if (k_q != 2'd3) begin
							k_q     <= k_q + 2'd1;
							state_q <= S_NB_ISSUE;
						end else if (sp_q == '0 && fb_rdata_q != ref_q) begin
							res_valid_q     <= 1'b1;
							res_q.read_data <= '0;
							res_q.status    <= sffe_pkg::ST_FILL_DONE;
							state_q         <= S_IDLE;
						end else begin
							state_q <= S_POP;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy         = (state_q != S_IDLE);
	assign result_valid = res_valid_q;
	assign result       = res_q;

endmodule

FILE: rtl/stack_flood_fill_engine_top.sv
// ----------------------------------------------------------------------------
// stack_flood_fill_engine_top
// Framebuffer with pixel write/read and a stack-driven 4-connected fill.
// ----------------------------------------------------------------------------
// Channel   Ports                               Handshake
// in        start, busy, req                    word taken when start && !busy
// out       result_valid, result                one-cycle strobe, no back-pressure
// cfg       cfg_we, cfg_index, cfg_wdata        write when cfg_we
//
// Write: one cycle, busy stays low. Read and bad coordinate: result two cycles
// or one cycle after the word. Fill: about 2 + per painted pixel 2 + up to 2
// per neighbor cycles, set by the single frame store read port.
// Reset clears control and the window registers; the frame store and stack
// hold garbage until written. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module stack_flood_fill_engine_top #(
	parameter int unsigned MAX_WIDTH   = sffe_pkg::DEF_MAX_WIDTH,
	parameter int unsigned MAX_HEIGHT  = sffe_pkg::DEF_MAX_HEIGHT,
	parameter int unsigned STACK_DEPTH = sffe_pkg::DEF_STACK_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  sffe_pkg::in_word_t            req,
	output logic                          result_valid,
	output sffe_pkg::out_word_t           result,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [sffe_pkg::REG_W-1:0]    cfg_wdata
);

	localparam int unsigned DW = sffe_pkg::DIM_W;

	logic [sffe_pkg::REG_W-1:0] frame_width_q, frame_height_q;
	sffe_pkg::win_t win;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= sffe_pkg::REG_W'(256);
			frame_height_q <= sffe_pkg::REG_W'(256);
		end else if (cfg_we) begin
			if (cfg_index == sffe_pkg::REG_FRAME_WIDTH) begin
				frame_width_q <= cfg_wdata;
			end
			if (cfg_index == sffe_pkg::REG_FRAME_HEIGHT) begin
				frame_height_q <= cfg_wdata;
			end
		end
	end

	// clamp window to the maximum frame size
	assign win.w = (DW'(frame_width_q) > DW'(MAX_WIDTH)) ? DW'(MAX_WIDTH) : DW'(frame_width_q);
	assign win.h = (DW'(frame_height_q) > DW'(MAX_HEIGHT)) ? DW'(MAX_HEIGHT)
		: DW'(frame_height_q);

	sffe_core #(
		.MAX_WIDTH   (MAX_WIDTH),
		.MAX_HEIGHT  (MAX_HEIGHT),
		.STACK_DEPTH (STACK_DEPTH)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.req          (req),
		.win          (win),
		.busy         (busy),
		.result_valid (result_valid),
		.result       (result)
	);

	// a result always leaves the engine idle
	a_res_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !busy)
		else $error("result while busy");

	// pixel writes give no result
	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && req.cmd == sffe_pkg::CMD_WRITE) |=> !result_valid)
		else $error("result after write");

	// only a successful read carries data
	a_zero_data: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.status != sffe_pkg::ST_READ_OK) |-> result.read_data == '0)
		else $error("nonzero data on fill or bad coordinate");

endmodule
